// File: hdl/bpec_pkg.sv
// shared types and constants for the bmp pixel to e-paper color converter
`timescale 1ns / 1ps

package bpec_pkg;

    // item kinds
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    // supported bits per pixel
    localparam logic [4:0] DEPTH_1  = 5'd1;
    localparam logic [4:0] DEPTH_4  = 5'd4;
    localparam logic [4:0] DEPTH_8  = 5'd8;
    localparam logic [4:0] DEPTH_16 = 5'd16;
    localparam logic [4:0] DEPTH_24 = 5'd24;

    // thresholds
    localparam logic [7:0] WHITE_LEVEL = 8'h80;
    localparam logic [9:0] WHITE_SUM   = 10'd384;
    localparam logic [7:0] COLOR_LEVEL = 8'hF0;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEPTH    = 2'd0,
        CFG_COLOR_EN = 2'd1,
        CFG_MULTI    = 2'd2,
        CFG_565      = 2'd3
    } t_cfg_idx;

    // output pixel classes
    typedef enum logic [1:0] {
        CLS_WHITE = 2'd0,
        CLS_BLACK = 2'd1,
        CLS_COLOR = 2'd2,
        CLS_FULL  = 2'd3
    } t_class;

    // palette entry: flags plus packed color
    typedef struct packed {
        logic        whitish;
        logic        colored;
        logic [15:0] rgb565;
    } t_entry;

    // one lane's view of a packed index
    typedef struct packed {
        logic       inr;
        logic [7:0] idx;
    } t_lane;

endpackage

// File: hdl/bmp_pixel_to_epaper_color.sv
// top level: bmp pixel to e-paper class converter with palette store and result sequencer
// path: a request's result passes the job register, the read stage and the output register
// throughput: one result per cycle unless the output stalls; a request holds the input until
//   its last pixel is issued, set by the single palette read port that the job sequencer
//   steps once per pixel; palette writes and direct 16/24-bit pixels can go back to back
// reset: synchronous active low; clears handshake state and restores the configuration registers,
//   palette contents stay undefined until written
`timescale 1ns / 1ps

module bmp_pixel_to_epaper_color #(
    parameter int PALETTE_ENTRIES     = 256,
    parameter int MAX_PIXELS_PER_ITEM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_palette_index,
    input  logic [23:0] i_data,
    input  logic [3:0]  i_pixel_count,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_pixel_class,
    output logic [15:0] o_rgb565,
    output logic        o_last
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int PW = (MAX_PIXELS_PER_ITEM > 1) ? $clog2(MAX_PIXELS_PER_ITEM) : 1;
    localparam logic [3:0] MAXP = 4'(MAX_PIXELS_PER_ITEM);

    // configuration registers
    logic [4:0] r_depth;
    logic       r_color_en;
    logic       r_multi;
    logic       r_565;

    // job register
    logic                r_job_vld;
    logic                r_job_direct;
    logic [PW-1:0]       r_pos;
    logic [PW-1:0]       r_last_pos;
    bpec_pkg::t_entry    r_dent;
    bpec_pkg::t_lane     r_lane [MAX_PIXELS_PER_ITEM];

    // read stage
    logic                r_rd_vld;
    logic                r_rd_last;
    logic                r_rd_direct;
    logic                r_rd_inr;
    bpec_pkg::t_entry    r_rd_dent;
    bpec_pkg::t_entry    r_mem_q;

    // output register
    logic                r_out_vld;
    bpec_pkg::t_class    r_out_class;
    logic [15:0]         r_out_rgb;
    logic                r_out_last;

    // palette store
    bpec_pkg::t_entry    mem [PALETTE_ENTRIES];

    // combinational
    logic [7:0]          w_b0, w_b1, w_b2;
    logic [7:0]          w_red, w_green, w_blue;
    logic                w_color_on;
    bpec_pkg::t_entry    w_ent;
    bpec_pkg::t_lane     w_lane [MAX_PIXELS_PER_ITEM];
    logic [3:0]          n_cnt;
    logic                n_direct;
    logic [3:0]          w_lim;
    logic                w_in_acc;
    logic                w_load;
    logic                w_pal_wr;
    logic                w_issue;
    logic                w_issue_last;
    logic                w_job_done;
    logic                w_adv_rd;
    logic                w_rd_free;
    bpec_pkg::t_entry    w_sel;
    bpec_pkg::t_class    n_class;

    assign w_b0 = i_data[7:0];
    assign w_b1 = i_data[15:8];
    assign w_b2 = i_data[23:16];

    assign w_color_on = r_color_en && (r_depth != bpec_pkg::DEPTH_1);

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= bpec_pkg::DEPTH_24;
            r_color_en <= 1'b1;
            r_multi    <= 1'b0;
            r_565      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bpec_pkg::t_cfg_idx'(i_cfg_index))
                bpec_pkg::CFG_DEPTH:    r_depth    <= i_cfg_data;
                bpec_pkg::CFG_COLOR_EN: r_color_en <= i_cfg_data[0];
                bpec_pkg::CFG_MULTI:    r_multi    <= i_cfg_data[0];
                bpec_pkg::CFG_565:      r_565      <= i_cfg_data[0];
                default:                r_depth    <= r_depth;
            endcase
        end
    end

    // channel unpacking for palette entries and direct pixels
    always_comb begin
        w_red   = w_b2;
        w_green = w_b1;
        w_blue  = w_b0;
        if (i_kind == bpec_pkg::KIND_PIXEL && r_depth == bpec_pkg::DEPTH_16) begin
            w_blue = {w_b0[4:0], 3'd0};
            if (r_565) begin
                w_green = {w_b1[2:0], w_b0[7:5], 2'd0};
                w_red   = {w_b1[7:3], 3'd0};
            end else begin
                w_green = {w_b1[1:0], w_b0[7:5], 3'd0};
                w_red   = {w_b1[6:2], 3'd0};
            end
        end
    end

    bpec_color u_color (
        .i_red      (w_red),
        .i_green    (w_green),
        .i_blue     (w_blue),
        .i_color_on (w_color_on),
        .o_entry    (w_ent)
    );

    // index lanes, one per pixel position
    for (genvar k = 0; k < MAX_PIXELS_PER_ITEM; k++) begin : g_lane
        bpec_lane #(
            .LANE            (k),
            .PALETTE_ENTRIES (PALETTE_ENTRIES)
        ) u_lane (
            .i_octet (w_b0),
            .i_depth (r_depth),
            .o_lane  (w_lane[k])
        );
    end

    // pixel count per request
    always_comb begin
        n_direct = 1'b0;
        w_lim    = 4'd0;
        n_cnt    = 4'd0;
        unique case (r_depth)
            bpec_pkg::DEPTH_24, bpec_pkg::DEPTH_16: begin
                n_direct = 1'b1;
                n_cnt    = 4'd1;
            end
            bpec_pkg::DEPTH_1: w_lim = 4'd8;
            bpec_pkg::DEPTH_4: w_lim = 4'd2;
            bpec_pkg::DEPTH_8: w_lim = 4'd1;
            default:           w_lim = 4'd0;
        endcase
        if (!n_direct) begin
            if (w_lim > MAXP) begin
                w_lim = MAXP;
            end
            n_cnt = (i_pixel_count > w_lim) ? w_lim : i_pixel_count;
        end
    end

    // handshake and sequencing
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_pal_wr     = w_in_acc && (i_kind == bpec_pkg::KIND_PALETTE)
                       && (32'(i_palette_index) < 32'(PALETTE_ENTRIES));
    assign w_load       = w_in_acc && (i_kind == bpec_pkg::KIND_PIXEL) && (n_cnt != 4'd0);
    assign w_adv_rd     = r_rd_vld && (!r_out_vld || i_out_ready);
    assign w_rd_free    = !r_rd_vld || w_adv_rd;
    assign w_issue      = r_job_vld && w_rd_free;
    assign w_issue_last = r_pos == r_last_pos;
    assign w_job_done   = w_issue && w_issue_last;
    assign o_in_ready   = !r_job_vld || w_job_done;

    // job register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
            r_pos     <= '0;
        end else begin
            if (w_load) begin
                r_job_vld <= 1'b1;
            end else if (w_job_done) begin
                r_job_vld <= 1'b0;
            end
            if (w_load) begin
                r_pos <= '0;
            end else if (w_issue && !w_issue_last) begin
                r_pos <= PW'(r_pos + 1'b1);
            end
        end
    end

    // job register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job_direct <= n_direct;
            r_last_pos   <= PW'(n_cnt - 4'd1);
            r_dent       <= w_ent;
            r_lane       <= w_lane;
        end
    end

    // palette store: write on palette requests, registered read per issued pixel
    always_ff @(posedge i_clk) begin
        if (w_pal_wr) begin
            mem[i_palette_index[AW-1:0]] <= w_ent;
        end
        if (w_issue) begin
            r_mem_q <= mem[r_lane[r_pos].idx[AW-1:0]];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (w_issue) begin
            r_rd_vld <= 1'b1;
        end else if (w_adv_rd) begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_last   <= w_issue_last;
            r_rd_direct <= r_job_direct;
            r_rd_inr    <= r_lane[r_pos].inr;
            r_rd_dent   <= r_dent;
        end
    end

    // merge: pick direct, palette or zero entry and classify
    always_comb begin
        if (r_rd_direct) begin
            w_sel = r_rd_dent;
        end else if (r_rd_inr) begin
            w_sel = r_mem_q;
        end else begin
            w_sel = '0;
        end
        priority if (w_color_on && r_multi) begin
            n_class = bpec_pkg::CLS_FULL;
        end else if (w_sel.whitish) begin
            n_class = bpec_pkg::CLS_WHITE;
        end else if (w_sel.colored && w_color_on) begin
            n_class = bpec_pkg::CLS_COLOR;
        end else begin
            n_class = bpec_pkg::CLS_BLACK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv_rd) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_rd) begin
            r_out_class <= n_class;
            r_out_rgb   <= w_sel.rgb565;
            r_out_last  <= r_rd_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_pixel_class = r_out_class;
    assign o_rgb565      = r_out_rgb;
    assign o_last        = r_out_last;

    // sequencer position never passes the last pixel of the job
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_vld |-> (r_pos <= r_last_pos))
        else $error("job position beyond last pixel");

    // a finished job with no new request leaves the job register empty
    a_job_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_job_done && !w_load) |=> !r_job_vld)
        else $error("job register not released");

    // palette read data holds while the read stage is stalled
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && !w_adv_rd) |=> $stable(r_mem_q) && r_rd_vld)
        else $error("read stage lost data while stalled");

    // direct pixels always form a single-result job
    a_direct_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_vld && r_job_direct) |-> (r_last_pos == '0))
        else $error("direct pixel job with more than one result");

endmodule

// File: hdl/bpec_color.sv
// color analysis: whitish and colored flags plus rgb565 packing from 8-bit channels
`timescale 1ns / 1ps

module bpec_color (
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    input  logic            i_color_on,
    output bpec_pkg::t_entry o_entry
);

    logic [9:0] w_sum;
    logic       w_strict;
    logic       w_loose;

    // whitish test, strict per channel or on the channel sum
    assign w_sum    = 10'(i_red) + 10'(i_green) + 10'(i_blue);
    assign w_strict = (i_red > bpec_pkg::WHITE_LEVEL) && (i_green > bpec_pkg::WHITE_LEVEL)
                   && (i_blue > bpec_pkg::WHITE_LEVEL);
    assign w_loose  = w_sum > bpec_pkg::WHITE_SUM;

    // entry assembly
    always_comb begin
        o_entry.whitish = i_color_on ? w_strict : w_loose;
        o_entry.colored = (i_red > bpec_pkg::COLOR_LEVEL)
                       || ((i_green > bpec_pkg::COLOR_LEVEL) && (i_blue > bpec_pkg::COLOR_LEVEL));
        o_entry.rgb565  = {i_red[7:3], i_green[7:2], i_blue[7:3]};
    end

endmodule

// File: hdl/bpec_lane.sv
// one index lane: pulls the palette index for a fixed position out of a packed byte
`timescale 1ns / 1ps

module bpec_lane #(
    parameter int LANE            = 0,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic [7:0]      i_octet,
    input  logic [4:0]      i_depth,
    output bpec_pkg::t_lane o_lane
);

    localparam int SH1 = LANE;
    localparam int SH4 = 4 * LANE;

    logic [15:0] w_sh1;
    logic [15:0] w_sh4;
    logic [7:0]  w_idx;

    // shift this lane's field to the top, msb first
    assign w_sh1 = 16'(i_octet) << SH1;
    assign w_sh4 = 16'(i_octet) << SH4;

    // field select per depth
    always_comb begin
        unique case (i_depth)
            bpec_pkg::DEPTH_1: w_idx = {7'd0, w_sh1[7]};
            bpec_pkg::DEPTH_4: w_idx = {4'd0, w_sh4[7:4]};
            bpec_pkg::DEPTH_8: w_idx = (LANE == 0) ? i_octet : 8'd0;
            default:           w_idx = 8'd0;
        endcase
    end

    // range check against the store depth
    assign o_lane.idx = w_idx;
    assign o_lane.inr = 32'(w_idx) < 32'(PALETTE_ENTRIES);

endmodule
